FILE: sv/timer_task_table_defines.svh
// ----------------------------------------------------------------------------
// timer_task_table_defines.svh
// Assertion macros for the timer task table. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TIMER_TASK_TABLE_DEFINES_SVH
`define TIMER_TASK_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: sv/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg
// Shared types and codes of the timer task table.
// ----------------------------------------------------------------------------
`default_nettype none

package ttt_pkg;

    // action codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_INIT   = 3'd3;
    localparam logic [2:0] ACT_DEINIT = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_INIT  = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_NULL_ID   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    // one table entry as stored in the entry memory
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] delay;
        logic [15:0] count;
        logic        periodic;
    } entry_t;

    // one result word toward the receiver
    typedef struct packed {
        logic       strobe;
        logic       fired;
        logic [7:0] fired_id;
        logic [2:0] status;
        logic       last;
    } result_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic initialized;
        logic nonempty;
    } seq_stat_t;

endpackage

`default_nettype wire

FILE: sv/timer_task_table.sv
// ----------------------------------------------------------------------------
// timer_task_table
// Table of software timer entries with start, stop, init, deinit and tick.
// ----------------------------------------------------------------------------
// Command channel: a word (action, task_id, delay, periodic) is taken at an
//   edge where start is high and busy is low; busy holds high while a stop
//   search or a counting pass walks the table.
// Result channel: each word shows for one cycle with result_strobe high and
//   cannot be stalled. A pass gives one fired word per firing task in table
//   order; every action ends with a status word with last high.
// Answers: init, deinit, start, errors and ticks without a pass answer in the
//   cycle after acceptance, so they can run one word per cycle. A stop walks
//   S_STOP_RD and S_STOP_EVAL per entry examined, S_STOP_MOVE if an entry
//   moves, then S_FINISH; a pass walks S_TICK_RD and S_TICK_EVAL per entry
//   visited, S_TICK_MOVE per one-shot that moves an entry, then S_FINISH.
//   RD states await the registered read. busy drops as the status word shows.
// cfg_wr_en writes ticks_per_period; write it only while idle. Reset empties
//   the table, clears init and the divider and sets ticks_per_period to 1;
//   memory contents stay, only slots below the fill mark are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_task_table_defines.svh"

module timer_task_table
    import ttt_pkg::*;
#(
    parameter int TASKS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  action,
    input  wire logic [7:0]  task_id,
    input  wire logic [15:0] delay,
    input  wire logic        periodic,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    output logic             result_strobe,
    output logic             fired,
    output logic [7:0]       fired_id,
    output logic [2:0]       status,
    output logic             last
);

    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    seq_stat_t        stat;
    result_t          result;
    logic             accept;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;

    logic [7:0]       tpp_reg, tpp_next;
    logic [7:0]       div_reg, div_next;
    logic [8:0]       div_inc;
    logic             pass_due;
    logic             tick_live;

    assign accept = start && !stat.busy;

    // Period divider: advance on every tick that finds a live, nonempty
    // table; wrap to zero and launch a pass once ticks_per_period is met.
    assign div_inc   = {1'b0, div_reg} + 9'd1;
    assign pass_due  = (div_inc >= {1'b0, tpp_reg});
    assign tick_live = accept && (action == ACT_TICK)
                       && stat.initialized && stat.nonempty;

    always_comb
    begin
        tpp_next = tpp_reg;
        div_next = div_reg;
        if (cfg_wr_en)
            tpp_next = cfg_wr_data;
        if (tick_live)
            div_next = pass_due ? 8'd0 : div_inc[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpp_reg <= 8'd1;
            div_reg <= 8'd0;
        end
        else
        begin
            tpp_reg <= tpp_next;
            div_reg <= div_next;
        end
    end

    ttt_seq #(
        .TASKS (TASKS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (action),
        .task_id   (task_id),
        .delay     (delay),
        .periodic  (periodic),
        .pass_due  (pass_due),
        .stat      (stat),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ttt_entry_ram #(
        .DEPTH (TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign busy          = stat.busy;
    assign result_strobe = result.strobe;
    assign fired         = result.fired;
    assign fired_id      = result.fired_id;
    assign status        = result.status;
    assign last          = result.last;

    // Single-step actions answer with a final word in the next cycle.
    `ASSERT_NEXT(a_quick_answer, accept && (action != ACT_TICK) && (action != ACT_STOP), result_strobe && last, "single-step action gave no final word")
    // A fired word always comes from inside a pass.
    `ASSERT_IMPLY(a_fire_in_pass, result_strobe && fired, busy && !last, "fired word outside a pass")
    // The final word releases the command channel.
    `ASSERT_IMPLY(a_last_idle, result_strobe && last, !busy, "busy after the final word")

endmodule

`default_nettype wire

FILE: sv/ttt_entry_ram.sv
// ----------------------------------------------------------------------------
// ttt_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_entry_ram
    import ttt_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire entry_t            wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output entry_t                 rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/ttt_seq.sv
// ----------------------------------------------------------------------------
// ttt_seq
// Action sequencer: appends, searches and walks the entry memory, and
// issues result words.
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_seq
    import ttt_pkg::*;
#(
    parameter int TASKS = 8,
    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1,
    localparam int CNT_W = $clog2(TASKS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [2:0]       action,
    input  wire logic [7:0]       task_id,
    input  wire logic [15:0]      delay,
    input  wire logic             periodic,
    input  wire logic             pass_due,
    output seq_stat_t             stat,
    output result_t               result,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output entry_t                mem_wdata,
    output logic [IDX_W-1:0]      mem_raddr,
    input  wire entry_t           mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_EVAL,
        S_TICK_MOVE,
        S_STOP_RD,
        S_STOP_EVAL,
        S_STOP_MOVE,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             init_reg, init_next;
    logic [7:0]       id_reg, id_next;
    result_t          res_reg, res_next;

    logic [CNT_W-1:0] used_m1;
    logic [IDX_W-1:0] last_idx;
    logic [CNT_W-1:0] idx_inc;
    logic             at_end;
    logic             is_last;
    logic [15:0]      cnt_inc;
    logic             fire;
    logic             idle_done;
    logic [2:0]       idle_st;

    assign used_m1  = used_reg - CNT_W'(1);
    assign last_idx = used_m1[IDX_W-1:0];
    assign idx_inc  = CNT_W'(idx_reg) + CNT_W'(1);
    assign at_end   = (idx_inc >= used_reg);
    assign is_last  = (idx_inc == used_reg);

    // saturate the elapsed count, then compare against the delay
    assign cnt_inc = (mem_rdata.count == 16'hFFFF) ? mem_rdata.count
                                                   : mem_rdata.count + 16'd1;
    assign fire    = (cnt_inc >= mem_rdata.delay);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        init_next  = init_reg;
        id_next    = id_reg;
        res_next   = '0;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = idx_reg;
        idle_done  = 1'b0;
        idle_st    = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idle_done = 1'b1;
                    case (action)
                        ACT_TICK:
                        begin
                            if (init_reg && (used_reg != '0) && pass_due)
                            begin
                                idle_done  = 1'b0;
                                idx_next   = '0;
                                state_next = S_TICK_RD;
                            end
                        end
                        ACT_START:
                        begin
                            if (!init_reg)
                                idle_st = ST_NOT_INIT;
                            else if (task_id == 8'd0)
                                idle_st = ST_NULL_ID;
                            else if (used_reg >= CNT_W'(TASKS))
                                idle_st = ST_FULL;
                            else
                            begin
                                // append at the fill mark
                                mem_we             = 1'b1;
                                mem_waddr          = used_reg[IDX_W-1:0];
                                mem_wdata.id       = task_id;
                                mem_wdata.delay    = delay;
                                mem_wdata.count    = 16'd0;
                                mem_wdata.periodic = periodic;
                                used_next          = used_reg + CNT_W'(1);
                            end
                        end
                        ACT_STOP:
                        begin
                            if (!init_reg)
                                idle_st = ST_NOT_INIT;
                            else if (used_reg == '0)
                                idle_st = ST_EMPTY;
                            else if (task_id == 8'd0)
                                idle_st = ST_NULL_ID;
                            else
                            begin
                                idle_done  = 1'b0;
                                id_next    = task_id;
                                idx_next   = '0;
                                state_next = S_STOP_RD;
                            end
                        end
                        ACT_INIT:
                        begin
                            if (init_reg)
                                idle_st = ST_ALREADY;
                            else
                            begin
                                used_next = '0;
                                init_next = 1'b1;
                            end
                        end
                        ACT_DEINIT:
                        begin
                            if (!init_reg)
                                idle_st = ST_NOT_INIT;
                            else
                            begin
                                used_next = '0;
                                init_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            idle_st = ST_OK;
                        end
                    endcase
                end
            end

            S_TICK_RD:
            begin
                state_next = S_TICK_EVAL;
            end

            S_TICK_EVAL:
            begin
                // prefetch the last entry in case this one leaves
                mem_raddr = last_idx;
                if (fire)
                begin
                    res_next.strobe   = 1'b1;
                    res_next.fired    = 1'b1;
                    res_next.fired_id = mem_rdata.id;
                end
                if (!fire || mem_rdata.periodic)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.count = fire ? 16'd0 : cnt_inc;
                    if (at_end)
                        state_next = S_FINISH;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_TICK_RD;
                    end
                end
                else if (is_last)
                begin
                    used_next  = used_m1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_TICK_MOVE;
                end
            end

            S_TICK_MOVE:
            begin
                // move the last entry in, then examine this slot again
                mem_we     = 1'b1;
                used_next  = used_m1;
                state_next = S_TICK_RD;
            end

            S_STOP_RD:
            begin
                state_next = S_STOP_EVAL;
            end

            S_STOP_EVAL:
            begin
                mem_raddr = last_idx;
                if (mem_rdata.id == id_reg)
                begin
                    if (is_last)
                    begin
                        used_next  = used_m1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_STOP_MOVE;
                    end
                end
                else if (at_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_STOP_RD;
                end
            end

            S_STOP_MOVE:
            begin
                mem_we     = 1'b1;
                used_next  = used_m1;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                res_next.strobe = 1'b1;
                res_next.status = ST_OK;
                res_next.last   = 1'b1;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (idle_done)
        begin
            res_next.strobe = 1'b1;
            res_next.status = idle_st;
            res_next.last   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            used_reg  <= '0;
            init_reg  <= 1'b0;
            id_reg    <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            init_reg  <= init_next;
            id_reg    <= id_next;
            res_reg   <= res_next;
        end
    end

    assign result           = res_reg;
    assign stat.busy        = (state_reg != S_IDLE);
    assign stat.initialized = init_reg;
    assign stat.nonempty    = (used_reg != '0);

endmodule

`default_nettype wire

FILE: bench/tb_timer_task_table.sv
// ----------------------------------------------------------------------------
// tb_timer_task_table
// Self-checking bench for the timer task table. Commands go in one word at
// a time through the start/busy handshake; a cycle-free model of the table
// predicts every result word, and each strobed word is checked field by
// field against the oldest prediction. Directed tests cover the error
// codes, a full table and one-shot removal during a pass; random phases
// run under several ticks_per_period settings with random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timer_task_table;
    import ttt_pkg::*;

    localparam int TASKS         = 8;
    // settle time, sized from the longest pass plus its status word
    localparam int SETTLE_CYCLES = 3 * TASKS + 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    // one result word as the receiver sees it
    typedef struct packed {
        logic       fired;
        logic [7:0] fired_id;
        logic [2:0] status;
        logic       last;
    } timer_word_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [2:0]  action      = ACT_TICK;
    logic [7:0]  task_id     = 8'd0;
    logic [15:0] delay       = 16'd0;
    logic        periodic    = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        busy;
    logic        result_strobe;
    logic        fired;
    logic [7:0]  fired_id;
    logic [2:0]  status;
    logic        last;

    timer_task_table #(
        .TASKS(TASKS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .task_id      (task_id),
        .delay        (delay),
        .periodic     (periodic),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_strobe(result_strobe),
        .fired        (fired),
        .fired_id     (fired_id),
        .status       (status),
        .last         (last)
    );

    // period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Table model: own copy of the entries, fill mark, divider and register
    // ------------------------------------------------------------------------
    logic [7:0]  tbl_id       [TASKS];
    logic [15:0] tbl_delay    [TASKS];
    logic [15:0] tbl_count    [TASKS];
    logic        tbl_periodic [TASKS];
    int          tbl_used;
    logic        tbl_initialized;
    logic [7:0]  tbl_divider;
    logic [7:0]  tbl_ticks_per_period;

    // predicted words, oldest first
    timer_word_t pending_words[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    // no sender gaps while set
    bit  steady_stream  = 1'b0;

    // wipe every slot and drop the fill mark
    function automatic void clear_entries();
        for (int i = 0; i < TASKS; i++)
        begin
            tbl_id[i]       = '0;
            tbl_delay[i]    = '0;
            tbl_count[i]    = '0;
            tbl_periodic[i] = 1'b0;
        end
        tbl_used = 0;
    endfunction

    // move the last entry into slot idx and clear the old last slot
    function automatic void remove_entry(input int idx);
        int tail;
        tail = tbl_used - 1;
        if (idx != tail)
        begin
            tbl_id[idx]       = tbl_id[tail];
            tbl_delay[idx]    = tbl_delay[tail];
            tbl_count[idx]    = tbl_count[tail];
            tbl_periodic[idx] = tbl_periodic[tail];
        end
        tbl_id[tail]       = '0;
        tbl_delay[tail]    = '0;
        tbl_count[tail]    = '0;
        tbl_periodic[tail] = 1'b0;
        tbl_used = tail;
    endfunction

    // Apply one accepted command word to the model and queue the words it
    // must produce: firings in table order, then the status word.
    function automatic void advance_timer_table(input logic [2:0] act, input logic [7:0] id,
                                                input logic [15:0] dly, input logic per);
        logic [2:0] st;
        int         i;
        st = ST_OK;
        case (act)
            ACT_TICK:
            begin
                // divider holds while not initialized or empty
                if (tbl_initialized && tbl_used > 0)
                begin
                    if (int'(tbl_divider) + 1 >= int'(tbl_ticks_per_period))
                    begin
                        tbl_divider = '0;
                        for (i = 0; i < tbl_used; i++)
                            if (tbl_count[i] != 16'hFFFF)
                                tbl_count[i] = tbl_count[i] + 16'd1;
                        i = 0;
                        while (i < tbl_used)
                        begin
                            if (tbl_count[i] >= tbl_delay[i])
                            begin
                                tbl_count[i] = '0;
                                pending_words.push_back(timer_word_t'{1'b1, tbl_id[i], ST_OK,
                                                                      1'b0});
                                // a one-shot leaves; re-examine the slot, it holds the mover
                                if (!tbl_periodic[i])
                                begin
                                    remove_entry(i);
                                    continue;
                                end
                            end
                            i++;
                        end
                    end
                    else
                        tbl_divider = tbl_divider + 8'd1;
                end
            end
            ACT_START:
            begin
                if (!tbl_initialized)
                    st = ST_NOT_INIT;
                else if (id == 8'd0)
                    st = ST_NULL_ID;
                else if (tbl_used >= TASKS)
                    st = ST_FULL;
                else
                begin
                    tbl_id[tbl_used]       = id;
                    tbl_delay[tbl_used]    = dly;
                    tbl_count[tbl_used]    = '0;
                    tbl_periodic[tbl_used] = per;
                    tbl_used++;
                end
            end
            ACT_STOP:
            begin
                if (!tbl_initialized)
                    st = ST_NOT_INIT;
                else if (tbl_used == 0)
                    st = ST_EMPTY;
                else if (id == 8'd0)
                    st = ST_NULL_ID;
                else
                begin
                    // first match only; a miss is still ok
                    for (i = 0; i < tbl_used; i++)
                    begin
                        if (tbl_id[i] == id)
                        begin
                            remove_entry(i);
                            break;
                        end
                    end
                end
            end
            ACT_INIT:
            begin
                if (tbl_initialized)
                    st = ST_ALREADY;
                else
                begin
                    clear_entries();
                    tbl_initialized = 1'b1;
                end
            end
            ACT_DEINIT:
            begin
                if (!tbl_initialized)
                    st = ST_NOT_INIT;
                else
                begin
                    clear_entries();
                    tbl_initialized = 1'b0;
                end
            end
            default:
            begin
                // codes past deinit do nothing
            end
        endcase
        pending_words.push_back(timer_word_t'{1'b0, 8'd0, st, 1'b1});
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every strobed word is taken at the edge ending its cycle
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0d] mismatch: %s", cycle_count, msg);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_words.size() == 0)
                note_mismatch($sformatf("unexpected word fired=%0b id=%02h status=%0d last=%0b",
                                        fired, fired_id, status, last));
            else
            begin
                timer_word_t want;
                want = pending_words.pop_front();
                if (fired !== want.fired || fired_id !== want.fired_id ||
                    status !== want.status || last !== want.last)
                    note_mismatch($sformatf({"expected fired=%0b id=%02h status=%0d last=%0b, ",
                                             "got fired=%0b id=%02h status=%0d last=%0b"},
                                            want.fired, want.fired_id, want.status, want.last,
                                            fired, fired_id, status, last));
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Send one command word. Idle first at random, then hold start high until
    // an edge with busy low takes the word. Start is left high so the next
    // call can follow back to back without a low/high pair in one step.
    task automatic issue_command(input logic [2:0] act, input logic [7:0] id,
                                 input logic [15:0] dly, input logic per);
        int gap;
        if (!steady_stream)
        begin
            while ($urandom_range(99) < 22)
            begin
                start <= 1'b0;
                // mostly the shortest gap, now and then a much longer one
                gap = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : 1;
                repeat (gap) @(posedge clk);
            end
        end
        start    <= 1'b1;
        action   <= act;
        task_id  <= id;
        delay    <= dly;
        periodic <= per;
        do
            @(posedge clk);
        while (busy);
        advance_timer_table(act, id, dly, per);
    endtask

    // Drop start, wait for every predicted word, then let the block settle.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write ticks_per_period; call only after drain_results.
    task automatic write_ticks_per_period(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        tbl_ticks_per_period = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Random task id: mostly a small pool so duplicates and stop hits occur
    function automatic logic [7:0] pick_task_id();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 8'($urandom_range(12, 1));
        else if (r < 90)
            return 8'd0;
        else
            return 8'($urandom_range(255));
    endfunction

    // Random delay: mostly short so passes fire, sometimes the full range
    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 16'($urandom_range(4));
        else if (r < 90)
            return 16'($urandom_range(40, 5));
        else
            return 16'($urandom_range(65535));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Commands before init other than init itself: tick is a silent ok, the rest are rejected.
    task automatic test_uninitialized();
        issue_command(ACT_TICK, 8'h00, 16'h0000, 1'b0);
        issue_command(ACT_START, 8'h05, 16'h0001, 1'b1);
        issue_command(ACT_STOP, 8'h05, 16'h0000, 1'b0);
        issue_command(ACT_DEINIT, 8'h00, 16'h0000, 1'b0);
        issue_command(ACT_START, 8'h00, 16'h0000, 1'b0);
        drain_results();
    endtask

    // Init/deinit ordering and the errors of an empty table.
    task automatic test_init_rules();
        issue_command(ACT_INIT, 8'h00, 16'h0000, 1'b0);
        issue_command(ACT_INIT, 8'h00, 16'h0000, 1'b0);   // already initialized
        issue_command(ACT_STOP, 8'h07, 16'h0000, 1'b0);   // empty
        issue_command(ACT_STOP, 8'h00, 16'h0000, 1'b0);   // empty wins over null id
        issue_command(ACT_TICK, 8'h00, 16'h0000, 1'b0);   // divider holds
        issue_command(ACT_START, 8'h00, 16'hFFFF, 1'b1);  // null id
        issue_command(ACT_DEINIT, 8'h00, 16'h0000, 1'b0);
        issue_command(ACT_DEINIT, 8'h00, 16'h0000, 1'b0); // not initialized
        issue_command(ACT_INIT, 8'h00, 16'h0000, 1'b0);
        drain_results();
    endtask

    // Fill the table, hit full, stop by first match, then fire through passes
    // where one-shots leave and the moved-in entry is looked at again.
    task automatic test_fill_and_fire();
        issue_command(ACT_START, 8'hFF, 16'h0000, 1'b1);
        issue_command(ACT_START, 8'h01, 16'hFFFF, 1'b0);
        issue_command(ACT_START, 8'hAA, 16'h0001, 1'b0);
        issue_command(ACT_START, 8'h55, 16'h0000, 1'b0);
        issue_command(ACT_START, 8'h01, 16'h0002, 1'b1);  // duplicate id
        issue_command(ACT_START, 8'h80, 16'h0003, 1'b0);
        issue_command(ACT_START, 8'h7F, 16'h0001, 1'b1);
        issue_command(ACT_START, 8'h02, 16'h0000, 1'b0);
        issue_command(ACT_START, 8'h03, 16'h0001, 1'b1);  // full
        issue_command(ACT_STOP, 8'h00, 16'h0000, 1'b0);   // null id on a full table
        issue_command(ACT_STOP, 8'h99, 16'h0000, 1'b0);   // miss, still ok
        issue_command(ACT_STOP, 8'h01, 16'h0000, 1'b0);   // first of two matches
        repeat (4) issue_command(ACT_TICK, 8'h00, 16'h0000, 1'b0);
        // codes past deinit are no-ops
        issue_command(3'd5, 8'hFF, 16'hFFFF, 1'b1);
        issue_command(3'd6, 8'h00, 16'h0000, 1'b0);
        issue_command(3'd7, 8'h5A, 16'hA5A5, 1'b1);
        issue_command(ACT_DEINIT, 8'h00, 16'h0000, 1'b0);
        drain_results();
    endtask

    // Mostly well-formed traffic that inits the table when needed, some noise.
    task automatic test_random_traffic(input int n_words, input logic [7:0] ticks);
        int         r;
        int         quiet_from;
        logic [2:0] act;
        logic [7:0] id;
        write_ticks_per_period(ticks);
        quiet_from = $urandom_range(n_words / 2);
        for (int k = 0; k < n_words; k++)
        begin
            // one stretch of back-to-back words
            steady_stream = (k >= quiet_from && k < quiet_from + 40);
            r  = $urandom_range(99);
            id = pick_task_id();
            if (!tbl_initialized && r < 70)
                act = ACT_INIT;
            else if (r < 42)
                act = ACT_TICK;
            else if (r < 67)
                act = ACT_START;
            else if (r < 85)
            begin
                act = ACT_STOP;
                // aim at a live entry most of the time
                if (tbl_used > 0 && $urandom_range(3) != 0)
                    id = tbl_id[$urandom_range(tbl_used - 1)];
            end
            else if (r < 89)
                act = ACT_INIT;
            else if (r < 92)
                act = ACT_DEINIT;
            else
                act = 3'($urandom_range(7));
            issue_command(act, id, pick_delay(), 1'($urandom_range(1)));
            // now and then hold off until everything has come back
            if ($urandom_range(24) == 0)
                drain_results();
        end
        steady_stream = 1'b0;
        drain_results();
    endtask

    // Largest divider: a nonempty table runs a pass only on every 255th tick.
    task automatic test_slow_divider();
        write_ticks_per_period(8'd255);
        issue_command(ACT_INIT, 8'h00, 16'h0000, 1'b0);
        issue_command(ACT_START, 8'hC3, 16'h0000, 1'b1);
        issue_command(ACT_START, 8'h3C, 16'h0001, 1'b0);
        for (int k = 0; k < 260; k++)
        begin
            steady_stream = (k < 100);
            issue_command(ACT_TICK, 8'($urandom_range(255)), 16'($urandom_range(65535)),
                          1'($urandom_range(1)));
        end
        steady_stream = 1'b0;
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_entries();
        tbl_initialized      = 1'b0;
        tbl_divider          = '0;
        tbl_ticks_per_period = 8'd1;

        // hold reset low from time zero, release it on an edge
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_uninitialized();
        test_init_rules();
        test_fill_and_fire();
        test_random_traffic(50, 8'd1);
        test_random_traffic(25, 8'd3);
        test_random_traffic(20, 8'd2);
        test_slow_divider();
        test_random_traffic(18, 8'd1);

        // drain_results already waited for the last word and settled
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: timer_task_table.f
+incdir+sv
sv/ttt_pkg.sv
sv/ttt_entry_ram.sv
sv/ttt_seq.sv
sv/timer_task_table.sv
bench/tb_timer_task_table.sv
